/* sv/json_string_unescaper_top_macros.svh */
// assertion helpers used by the unescaper output queue
`ifndef JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPER_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition this cycle implies consequence in the next cycle
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_DONE   = 3'd1,
    ST_NOOPEN = 3'd2,
    ST_TRAIL  = 3'd3,
    ST_SHORTU = 3'd4,
    ST_BADHEX = 3'd5,
    ST_UNKESC = 3'd6,
    ST_UNTERM = 3'd7
  } status_e;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } result_t;

  localparam int unsigned MaxResults = 3;

  // all result words caused by one input word
  typedef struct packed {
    logic [1:0]                   n;
    result_t [MaxResults-1:0]     res;
  } bundle_t;

endpackage

/* sv/jsu_in_if.sv */
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

/* sv/jsu_out_if.sv */
`timescale 1ns / 1ps

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

/* sv/json_string_unescaper_top.sv */
`timescale 1ns / 1ps

// JSON string unescaper. Feed a quoted JSON string one byte per word on in_i, starting at the
// opening quote; set end_of_text on a word to mark the end of the text. Decoded bytes leave on
// out_o with status 0, the closing quote gives status 1, and errors give status 2..7; any
// status other than 0 ends the string and the block then expects a new opening quote. The
// simple escapes map to one byte and a \uXXXX escape leaves as one to three UTF-8 bytes, with
// surrogates replaced by U+FFFD; last marks the final word caused by one input word. Input is
// taken at one word per cycle while in_i.ready is high, and results are registered in the output
// queue before they appear on out_o. The four-word output queue drains one word per cycle while
// out_o.ready is high; input is held off only while more than one word would remain in it after
// this cycle's output, so the output port's one word per cycle is what bounds throughput.
module json_string_unescaper_top (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  logic    accept;
  logic    pop;
  logic    room;
  logic    head_valid;
  bundle_t bundle;
  result_t head;

  // input word taken when the queue can hold a full burst
  assign in_i.ready = room;
  assign accept     = in_i.valid & room;
  assign pop        = head_valid & out_o.ready;

  // state machine and utf-8 encoder
  jsu_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_i.in_byte),
    .end_of_text_i (in_i.end_of_text),
    .bundle_o      (bundle)
  );

  // result register stage, up to one burst plus one waiting word
  jsu_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .bundle_i     (bundle),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  assign out_o.valid    = head_valid;
  assign out_o.out_byte = head.out_byte;
  assign out_o.status   = head.status;
  assign out_o.last     = head.last;

endmodule

/* sv/jsu_decoder.sv */
`timescale 1ns / 1ps

module jsu_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_text_i,
  output jsu_pkg::bundle_t bundle_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [15:0] SurrLo  = 16'hD800;
  localparam logic [15:0] SurrHi  = 16'hDFFF;
  localparam logic [15:0] Repl    = 16'hFFFD;
  localparam logic [15:0] Lim1    = 16'h0080;
  localparam logic [15:0] Lim2    = 16'h0800;
  localparam logic [7:0]  Lead2   = 8'hC0;
  localparam logic [7:0]  Lead3   = 8'hE0;
  localparam logic [7:0]  Cont    = 8'h80;
  localparam logic [5:0]  ContMsk = 6'h3F;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    logic [4:0] v;
    t = 8'd0;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      v = {1'b0, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      v = {1'b0, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      v = {1'b0, t[3:0]};
    end
    return v;
  endfunction

  function automatic result_t mk(input logic [7:0] b, input status_e s, input logic l);
    result_t r;
    r.out_byte = b;
    r.status   = s;
    r.last     = l;
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;

  logic [4:0]  hv;
  logic [15:0] cp_full;
  logic [15:0] cp_enc;
  bundle_t     bun;

  assign hv      = hex_val(in_byte_i);
  assign cp_full = {cp_q[11:0], hv[3:0]};
  assign cp_enc  = (cp_full >= SurrLo && cp_full <= SurrHi) ? Repl : cp_full;

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    bun.n     = 2'd0;
    for (int k = 0; k < MaxResults; k++) begin
      bun.res[k] = mk(8'h00, ST_BYTE, 1'b0);
    end

    unique case (phase_q)
      PH_WAIT: begin
        if (!end_of_text_i && in_byte_i == ChQuote) begin
          phase_d = PH_STR;
        end else begin
          bun.n      = 2'd1;
          bun.res[0] = mk(8'h00, ST_NOOPEN, 1'b1);
        end
      end
      PH_STR: begin
        priority if (end_of_text_i) begin
          bun.n      = 2'd1;
          bun.res[0] = mk(8'h00, ST_UNTERM, 1'b1);
          phase_d    = PH_WAIT;
        end else if (in_byte_i == ChQuote) begin
          bun.n      = 2'd1;
          bun.res[0] = mk(8'h00, ST_DONE, 1'b1);
          phase_d    = PH_WAIT;
        end else if (in_byte_i == ChBslash) begin
          phase_d = PH_ESC;
        end else begin
          bun.n      = 2'd1;
          bun.res[0] = mk(in_byte_i, ST_BYTE, 1'b1);
        end
      end
      PH_ESC: begin
        bun.n   = 2'd1;
        phase_d = PH_STR;
        if (end_of_text_i) begin
          bun.res[0] = mk(8'h00, ST_TRAIL, 1'b1);
          phase_d    = PH_WAIT;
        end else begin
          unique case (in_byte_i)
            ChQuote:  bun.res[0] = mk(ChQuote, ST_BYTE, 1'b1);
            ChBslash: bun.res[0] = mk(ChBslash, ST_BYTE, 1'b1);
            ChSlash:  bun.res[0] = mk(ChSlash, ST_BYTE, 1'b1);
            ChN:      bun.res[0] = mk(8'h0A, ST_BYTE, 1'b1);
            ChT:      bun.res[0] = mk(8'h09, ST_BYTE, 1'b1);
            ChR:      bun.res[0] = mk(8'h0D, ST_BYTE, 1'b1);
            ChB:      bun.res[0] = mk(8'h08, ST_BYTE, 1'b1);
            ChF:      bun.res[0] = mk(8'h0C, ST_BYTE, 1'b1);
            ChU: begin
              bun.n     = 2'd0;
              phase_d   = PH_HEX;
              hex_cnt_d = 2'd0;
              cp_d      = 16'h0000;
            end
            default: begin
              bun.res[0] = mk(8'h00, ST_UNKESC, 1'b1);
              phase_d    = PH_WAIT;
            end
          endcase
        end
      end
      PH_HEX: begin
        priority if (end_of_text_i) begin
          bun.n      = 2'd1;
          bun.res[0] = mk(8'h00, ST_SHORTU, 1'b1);
          phase_d    = PH_WAIT;
        end else if (hv[4]) begin
          bun.n      = 2'd1;
          bun.res[0] = mk(8'h00, ST_BADHEX, 1'b1);
          phase_d    = PH_WAIT;
        end else if (hex_cnt_q == 2'd3) begin
          phase_d   = PH_STR;
          hex_cnt_d = 2'd0;
          cp_d      = 16'h0000;
          // utf-8 encode, one to three words
          priority if (cp_enc < Lim1) begin
            bun.n      = 2'd1;
            bun.res[0] = mk(cp_enc[7:0], ST_BYTE, 1'b1);
          end else if (cp_enc < Lim2) begin
            bun.n      = 2'd2;
            bun.res[0] = mk(Lead2 | {3'b000, cp_enc[10:6]}, ST_BYTE, 1'b0);
            bun.res[1] = mk(Cont | {2'b00, cp_enc[5:0] & ContMsk}, ST_BYTE, 1'b1);
          end else begin
            bun.n      = 2'd3;
            bun.res[0] = mk(Lead3 | {4'b0000, cp_enc[15:12]}, ST_BYTE, 1'b0);
            bun.res[1] = mk(Cont | {2'b00, cp_enc[11:6]}, ST_BYTE, 1'b0);
            bun.res[2] = mk(Cont | {2'b00, cp_enc[5:0] & ContMsk}, ST_BYTE, 1'b1);
          end
        end else begin
          cp_d      = cp_full;
          hex_cnt_d = hex_cnt_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase

    // any finishing status returns to the reset state
    if (phase_d == PH_WAIT) begin
      hex_cnt_d = 2'd0;
      cp_d      = 16'h0000;
    end
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      hex_cnt_q <= 2'd0;
      cp_q      <= 16'h0000;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

/* sv/jsu_out_queue.sv */
`timescale 1ns / 1ps
`include "json_string_unescaper_top_macros.svh"

module jsu_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsu_pkg::bundle_t bundle_i,
  input  logic             pop_i,
  output logic             room_o,
  output logic             head_valid_o,
  output jsu_pkg::result_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned Depth = MaxResults + 1;

  result_t    slots_q [Depth];
  result_t    slots_d [Depth];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] base;
  logic [2:0] off [Depth];

  // words left once this cycle's pop is done
  assign base         = cnt_q - {2'b00, pop_i};
  assign room_o       = (base <= 3'd1);
  assign head_valid_o = (cnt_q != 3'd0);
  assign head_o       = slots_q[0];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      off[i] = 3'(i) - base;
      if (pop_i && i < Depth - 1) begin
        slots_d[i] = slots_q[i+1];
      end else begin
        slots_d[i] = slots_q[i];
      end
      // new burst lands right behind what remains
      if (push_i && off[i] < {1'b0, bundle_i.n}) begin
        slots_d[i] = bundle_i.res[off[i][1:0]];
      end
    end
    cnt_d = push_i ? base + {1'b0, bundle_i.n} : base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slots_q[i] <= slots_d[i];
    end
  end

  `JSU_ASSERT(a_cnt_max, cnt_q <= 3'd4, "queue fill beyond depth")
  `JSU_ASSERT(a_no_overflow, push_i |-> ((base + {1'b0, bundle_i.n}) <= 3'd4), "burst overflows queue")
  `JSU_ASSERT(a_burst_whole, (cnt_q != 3'd0 && !slots_q[0].last) |-> (cnt_q >= 3'd2), "burst split")
  `JSU_ASSERT_NEXT(a_burst_cont, pop_i && !slots_q[0].last, cnt_q != 3'd0, "burst tail missing")

endmodule
